@@ rtl/core/mpst_pkg.sv @@
// Package for the Manchester pulse serial transmitter core.
// Holds the register map, the configuration and result structs and reset values.
// No dependencies.
package mpst_pkg;

  localparam int unsigned TickW = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CfgStartTicks = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSlotTicks  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHalfTicks  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStopTicks  = 3'd3;

  localparam logic [TickW-1:0] StartTicksRst = 16'd24000;
  localparam logic [TickW-1:0] SlotTicksRst  = 16'd12000;
  localparam logic [TickW-1:0] HalfTicksRst  = 16'd4000;
  localparam logic [TickW-1:0] StopTicksRst  = 16'd4000;

  localparam logic ModeTick = 1'b0;
  localparam logic ModeLoad = 1'b1;

  typedef struct packed {
    logic [TickW-1:0] start_ticks;
    logic [TickW-1:0] slot_ticks;
    logic [TickW-1:0] half_ticks;
    logic [TickW-1:0] stop_ticks;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic load_accepted;
  } res_t;

endpackage

@@ rtl/core/mpst_cfg.sv @@
// Configuration register file of the transmitter core.
// Depends on mpst_pkg for the register map and reset values.
module mpst_cfg
  import mpst_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TickW-1:0]   cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_ticks <= StartTicksRst;
      cfg_q.slot_ticks  <= SlotTicksRst;
      cfg_q.half_ticks  <= HalfTicksRst;
      cfg_q.stop_ticks  <= StopTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStartTicks: cfg_q.start_ticks <= cfg_data_i;
        CfgSlotTicks:  cfg_q.slot_ticks  <= cfg_data_i;
        CfgHalfTicks:  cfg_q.half_ticks  <= cfg_data_i;
        CfgStopTicks:  cfg_q.stop_ticks  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/mpst_engine.sv @@
// Frame sequencer: phase, tick counter, bit position and shift byte.
// Depends on mpst_pkg for cfg_t, res_t and the mode codes.
module mpst_engine
  import mpst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic       mode_i,
  input  logic [7:0] data_byte_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  typedef enum logic [1:0] {
    PhIdle,
    PhStart,
    PhData,
    PhStop
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [TickW-1:0] cnt_q, cnt_d;
  logic [2:0]       bit_q, bit_d;
  logic [7:0]       shift_q, shift_d;
  logic             line_q, line_d;
  logic [TickW-1:0] cnt_inc;
  logic             accepted;

  assign cnt_inc = cnt_q + 16'd1;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    line_d   = line_q;
    accepted = 1'b0;
    if (mode_i == ModeLoad) begin
      if (phase_q == PhIdle) begin
        shift_d  = data_byte_i;
        bit_d    = 3'd0;
        cnt_d    = '0;
        phase_d  = PhStart;
        line_d   = 1'b0;
        accepted = 1'b1;
      end
    end else begin
      case (phase_q)
        PhIdle: line_d = 1'b1;
        PhStart: begin
          if (cnt_inc >= cfg_i.start_ticks) begin
            phase_d = PhData;
            bit_d   = 3'd0;
            cnt_d   = '0;
            // The slot begins at count zero, so only a zero half length flips it.
            line_d  = (cfg_i.half_ticks == '0) ? ~shift_q[0] : shift_q[0];
          end else begin
            cnt_d  = cnt_inc;
            line_d = 1'b0;
          end
        end
        PhData: begin
          if (cnt_inc >= cfg_i.slot_ticks) begin
            cnt_d = '0;
            if (bit_q == 3'd7) begin
              bit_d   = 3'd0;
              phase_d = (cfg_i.stop_ticks == '0) ? PhIdle : PhStop;
              line_d  = 1'b1;
            end else begin
              bit_d   = bit_q + 3'd1;
              shift_d = {1'b0, shift_q[7:1]};
              line_d  = (cfg_i.half_ticks == '0) ? ~shift_q[1] : shift_q[1];
            end
          end else begin
            cnt_d  = cnt_inc;
            line_d = (cnt_inc >= cfg_i.half_ticks) ? ~shift_q[0] : shift_q[0];
          end
        end
        PhStop: begin
          line_d = 1'b1;
          if (cnt_inc >= cfg_i.stop_ticks) begin
            phase_d = PhIdle;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        default: phase_d = PhIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= '0;
      bit_q   <= 3'd0;
      shift_q <= 8'd0;
      line_q  <= 1'b1;
    end else if (adv_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      line_q  <= line_d;
    end
  end

  assign res_o.line_level    = line_d;
  assign res_o.busy_res      = (phase_d != PhIdle);
  assign res_o.load_accepted = accepted;

endmodule

@@ rtl/core/manchester_pulse_serial_transmitter_core.sv @@
// Top level of the Manchester pulse serial transmitter core.
// Instantiates mpst_cfg and mpst_engine; depends on mpst_pkg.
//
// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+---------------------------------------
// in      | sink      | in_valid_i/in_stall_o | mode_i, data_byte_i
// out     | source    | out_valid_o/out_stall_i | line_level_o, busy_res_o, load_accepted_o
// cfg     | sink      | cfg_we_i            | cfg_idx_i, cfg_data_i
//
// Every item passes through the input register and then, through the frame
// sequencer, into the result register. One item is taken per cycle while
// the result side does not stall; the sequencer's state update is the loop
// that sets that rate. Reset returns the registers to their defaults,
// the sequencer to idle with the line high, and both stages to empty. A stall
// on the result side holds the result register and then the input register;
// the input side stalls only while the input register cannot move on.
module manchester_pulse_serial_transmitter_core
  import mpst_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TickW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               line_level_o,
  output logic               busy_res_o,
  output logic               load_accepted_o
);

  cfg_t       cfg;
  res_t       res;
  res_t       res_q;
  logic       in_vld_q;
  logic       mode_q;
  logic [7:0] byte_q;
  logic       out_vld_q;
  logic       out_rdy;
  logic       adv;
  logic       in_xfer;

  mpst_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The result register can take a new value when it is empty or being drained.
  assign out_rdy    = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && out_rdy;
  assign in_stall_o = in_vld_q && !out_rdy;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Input register stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q <= mode_i;
      byte_q <= data_byte_i;
    end
  end

  // The sequencer commits its state only when the item moves into the result register.
  mpst_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .mode_i      (mode_q),
    .data_byte_i (byte_q),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  // Result register stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign line_level_o    = res_q.line_level;
  assign busy_res_o      = res_q.busy_res;
  assign load_accepted_o = res_q.load_accepted;

  // A frame that was just started is busy and drives the line low.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && load_accepted_o |-> busy_res_o && !line_level_o)
    else $error("accepted load without busy low line");

  // An idle line is always high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> line_level_o)
    else $error("idle line not high");

  // The input side stalls only while an item waits in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q && out_stall_i)
    else $error("input stall without a blocked item");

  // A held item moves on into the result register once the output drains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_rdy |=> out_vld_q)
    else $error("advanced item lost");

endmodule
